>>> hdl/ncq_pkg.sv
// Shared types, widths and the codebook ROM for the nearest-codeword quantiser.
// Used by ncq_cell, nearest_codeword_quantizer and tb_top; depends on nothing else.
`timescale 1ns / 1ps

package ncq_pkg;

  // Sizes of the codebook and of one embedding component
  localparam int CODEWORDS = 16;
  localparam int DIMS      = 3;
  localparam int COMP_BITS = 16;

  // Derived widths: difference, square, sum of squares, codeword index
  localparam int DIFF_W = COMP_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W - 1;
  localparam int DIST_W = SQ_W + $clog2(DIMS);
  localparam int ID_W   = $clog2(CODEWORDS);

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef comp_t [DIMS-1:0]            vec_t;
  typedef logic [SQ_W-1:0]             sq_t;
  typedef logic [DIST_W-1:0]           dist_t;
  typedef logic [ID_W-1:0]             id_t;

  // What travels from one cell to the next with each item
  typedef struct packed {
    vec_t  vec;
    dist_t best_dist;
    id_t   best_id;
    logic  seeded;     // a best distance has been recorded
  } link_t;

  // Codebook, Q4.12, entries in component order 0..DIMS-1
  localparam comp_t CODEBOOK [CODEWORDS][DIMS] = '{
    '{ -16'sd5270,   16'sd4813,  -16'sd3281},
    '{ -16'sd7380,  -16'sd4383,   16'sd5427},
    '{ -16'sd5170,  -16'sd3360,  -16'sd6353},
    '{-16'sd11814,   16'sd2260,   16'sd5051},
    '{ -16'sd1650,   16'sd3251,   16'sd4257},
    '{ -16'sd6327,   -16'sd945,   16'sd4221},
    '{  16'sd1882,   16'sd4128,  -16'sd5624},
    '{   16'sd813,   16'sd3272,  -16'sd5166},
    '{ -16'sd3571,   -16'sd538,  -16'sd4185},
    '{  16'sd2537,   -16'sd166,  -16'sd6842},
    '{ -16'sd6506,   16'sd3037,   16'sd2521},
    '{   16'sd158,   16'sd8221,   16'sd5846},
    '{ -16'sd3384,  -16'sd2318,   16'sd2983},
    '{ -16'sd2883,   16'sd2304,    16'sd752},
    '{   16'sd276,  -16'sd3003,  -16'sd4554},
    '{    16'sd89,  -16'sd1230,   16'sd1564}
  };

endpackage

>>> hdl/nearest_codeword_quantizer.sv
// Top level of the nearest-codeword quantiser: chain of ncq_cell plus output skid.
// Depends on ncq_pkg and ncq_cell.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid_i / in_stall_o with comp_0_i..comp_2_i, three
//   signed Q4.12 components of one voxel embedding. An item is taken at a
//   rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i with nearest_id_o, the index
//   of the nearest of the 16 ROM codewords by squared distance (lowest index
//   on a tie). One result per input item, in input order.
//   Path: an accepted item passes two register stages per codeword cell
//   (16 cells, the first loaded at the accepting edge), then the output
//   register, before out_valid_o rises.
//   Throughput: one item per cycle unless held; each stage holds its own item.
//   Stalls: the chain advances as long as the skid register is empty, so
//   items keep being taken while a result waits at the output. A second
//   result arriving behind a stalled one parks in the skid register; the
//   chain then holds and in_stall_o goes high until the skid drains.
//   Reset: rst_ni clears all valid flags; the pipeline comes up empty and
//   ready, with no start-up pass.

module nearest_codeword_quantizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ncq_pkg::COMP_BITS-1:0] comp_0_i,
  input  logic signed [ncq_pkg::COMP_BITS-1:0] comp_1_i,
  input  logic signed [ncq_pkg::COMP_BITS-1:0] comp_2_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ncq_pkg::ID_W-1:0]            nearest_id_o
);
  import ncq_pkg::*;

  logic  chain_valid [CODEWORDS+1];
  link_t chain_link  [CODEWORDS+1];
  logic  en;

  logic  out_valid_q, out_valid_d;
  id_t   out_id_q, out_id_d;
  logic  skid_valid_q, skid_valid_d;
  id_t   skid_id_q, skid_id_d;

  logic  last_valid;
  id_t   last_id;
  logic  out_free;

  // The chain moves whenever the skid register has room
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Head of the chain: no best recorded yet
  always_comb begin
    chain_valid[0]          = in_valid_i;
    chain_link[0].vec[0]    = comp_0_i;
    chain_link[0].vec[1]    = comp_1_i;
    chain_link[0].vec[2]    = comp_2_i;
    chain_link[0].best_dist = '0;
    chain_link[0].best_id   = '0;
    chain_link[0].seeded    = 1'b0;
  end

  // One cell per codeword
  for (genvar k = 0; k < CODEWORDS; k++) begin : g_cell
    vec_t code;
    always_comb begin
      for (int d = 0; d < DIMS; d++) begin
        code[d] = CODEBOOK[k][d];
      end
    end

    ncq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (chain_valid[k]),
      .link_i    (chain_link[k]),
      .code_i    (code),
      .cell_id_i (ID_W'(k)),
      .valid_o   (chain_valid[k+1]),
      .link_o    (chain_link[k+1])
    );
  end

  assign last_valid = chain_valid[CODEWORDS] && en;
  assign last_id    = chain_link[CODEWORDS].best_id;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Output register with skid: skid first, then the chain's last cell
  always_comb begin
    out_valid_d  = out_valid_q;
    out_id_d     = out_id_q;
    skid_valid_d = skid_valid_q;
    skid_id_d    = skid_id_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_id_d     = skid_id_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = last_valid;
        out_id_d    = last_id;
      end
    end else if (last_valid) begin
      skid_valid_d = 1'b1;
      skid_id_d    = last_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_id_q  <= out_id_d;
    skid_id_q <= skid_id_d;
  end

  assign out_valid_o  = out_valid_q;
  assign nearest_id_o = out_id_q;

`ifndef SYNTHESIS
  // The skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output is empty");

  // A parked item moves to the output once the held one is taken
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid did not drain into output");

  // An item held at the end while output and skid are busy never overwrites the skid
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && chain_valid[CODEWORDS]) |=> $stable(skid_id_q) || !skid_valid_q)
    else $error("skid overwritten");
`endif

endmodule

>>> hdl/ncq_cell.sv
// One cell of the quantiser chain: distance to one codeword, keep the nearer.
// Depends on ncq_pkg (link_t, vec_t, id_t and widths).
`timescale 1ns / 1ps

module ncq_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ncq_pkg::link_t link_i,
  input  ncq_pkg::vec_t code_i,
  input  ncq_pkg::id_t  cell_id_i,
  output logic          valid_o,
  output ncq_pkg::link_t link_o
);
  import ncq_pkg::*;

  logic  valid_a_q;
  link_t link_a_q;
  sq_t   sq_a_q [DIMS];
  sq_t   sq_a_d [DIMS];

  logic  valid_b_q;
  link_t link_b_q;
  link_t link_b_d;
  dist_t dist_sum;
  logic  take;

  // Stage A: per-component difference and square
  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int d = 0; d < DIMS; d++) begin
      diff      = DIFF_W'($signed(link_i.vec[d])) - DIFF_W'($signed(code_i[d]));
      prod      = diff * diff;
      sq_a_d[d] = prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      link_a_q <= link_i;
      sq_a_q   <= sq_a_d;
    end
  end

  // Stage B: sum of squares, strict compare so the lower index wins ties
  always_comb begin
    dist_sum = '0;
    for (int d = 0; d < DIMS; d++) begin
      dist_sum = dist_sum + DIST_W'(sq_a_q[d]);
    end
    take     = !link_a_q.seeded || (dist_sum < link_a_q.best_dist);
    link_b_d = link_a_q;
    link_b_d.seeded = 1'b1;
    if (take) begin
      link_b_d.best_dist = dist_sum;
      link_b_d.best_id   = cell_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      link_b_q <= link_b_d;
    end
  end

  assign valid_o = valid_b_q;
  assign link_o  = link_b_q;

`ifndef SYNTHESIS
  // Every item leaving a cell carries a recorded best
  a_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> link_o.seeded)
    else $error("item left cell without a best distance");

  // The best index can never point past this cell
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (link_o.best_id <= cell_id_i))
    else $error("best index beyond current cell");

  // The best distance never grows along the chain
  a_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_a_q && link_a_q.seeded) |=>
      (link_o.best_dist <= $past(link_a_q.best_dist)))
    else $error("best distance increased");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for nearest_codeword_quantizer: directed and random voxels,
// random idling on both channels, checked by a scoreboard with its own codebook search.
// Depends on ncq_pkg and the nearest_codeword_quantizer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int RUN_LIMIT     = 200000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_BLOCKS = 8;
  localparam int BLOCK_VOXELS  = 100;

  // Codebook in Q4.12, one row per codeword
  localparam int CODE_ROM [16][3] = '{
    '{ -5270,  4813, -3281},
    '{ -7380, -4383,  5427},
    '{ -5170, -3360, -6353},
    '{-11814,  2260,  5051},
    '{ -1650,  3251,  4257},
    '{ -6327,  -945,  4221},
    '{  1882,  4128, -5624},
    '{   813,  3272, -5166},
    '{ -3571,  -538, -4185},
    '{  2537,  -166, -6842},
    '{ -6506,  3037,  2521},
    '{   158,  8221,  5846},
    '{ -3384, -2318,  2983},
    '{ -2883,  2304,   752},
    '{   276, -3003, -4554},
    '{    89, -1230,  1564}
  };

  // Holds the expected codeword index of every item in flight
  class quant_scoreboard;
    ncq_pkg::id_t want_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // Exhaustive search, exact 64-bit distances; strict compare keeps the lowest index
    function ncq_pkg::id_t nearest_of(ncq_pkg::comp_t c0, ncq_pkg::comp_t c1,
                                      ncq_pkg::comp_t c2);
      longint       vec [3];
      longint       best_dist;
      longint       dist_sum;
      longint       diff;
      ncq_pkg::id_t best_id;
      vec[0]    = c0;
      vec[1]    = c1;
      vec[2]    = c2;
      best_dist = 0;
      best_id   = '0;
      for (int k = 0; k < 16; k++) begin
        dist_sum = 0;
        for (int d = 0; d < 3; d++) begin
          diff = vec[d] - longint'(CODE_ROM[k][d]);
          dist_sum += diff * diff;
        end
        if (k == 0 || dist_sum < best_dist) begin
          best_dist = dist_sum;
          best_id   = ncq_pkg::id_t'(k);
        end
      end
      return best_id;
    endfunction

    function void note_voxel(ncq_pkg::comp_t c0, ncq_pkg::comp_t c1, ncq_pkg::comp_t c2);
      want_q.push_back(nearest_of(c0, c1, c2));
    endfunction

    function void check_id(ncq_pkg::id_t got);
      ncq_pkg::id_t want;
      if (want_q.size() == 0) begin
        $error("nearest_id: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got !== want) begin
        $error("nearest_id: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  ncq_pkg::comp_t             comp_0_i    = '0;
  ncq_pkg::comp_t             comp_1_i    = '0;
  ncq_pkg::comp_t             comp_2_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  ncq_pkg::id_t               nearest_id_o;

  quant_scoreboard            sb          = new();
  bit                         calm        = 1'b0;  // no idling on either side
  int                         cycle_count = 0;

  nearest_codeword_quantizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .comp_0_i     (comp_0_i),
    .comp_1_i     (comp_1_i),
    .comp_2_i     (comp_2_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .nearest_id_o (nearest_id_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Both channels sampled at the edge, before any update of that step
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) sb.note_voxel(comp_0_i, comp_1_i, comp_2_i);
      if (out_valid_o === 1'b1 && !out_stall_i) sb.check_id(nearest_id_o);
    end
  end

  // Receiver: random stall ahead of each result, none while calm
  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Present one item after a random gap, none while calm; returns at its acceptance edge
  task automatic send_voxel(input ncq_pkg::comp_t c0, input ncq_pkg::comp_t c1,
                            input ncq_pkg::comp_t c2);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    comp_0_i   <= c0;
    comp_1_i   <= c1;
    comp_2_i   <= c2;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Hold the input off until every item in flight has produced its result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Random voxel: full range, near a codeword, midway between two, or per component a range end, zero or -1
  task automatic send_random_voxel();
    ncq_pkg::comp_t v [3];
    int             kind;
    int             row;
    int             other;
    int             off;
    kind  = $urandom_range(0, 9);
    row   = $urandom_range(0, 15);
    other = $urandom_range(0, 15);
    for (int d = 0; d < 3; d++) begin
      off = $urandom_range(0, 2048);
      if (kind < 4)
        v[d] = ncq_pkg::comp_t'($urandom);
      else if (kind < 7)
        v[d] = ncq_pkg::comp_t'(CODE_ROM[row][d] + off - 1024);
      else if (kind < 9)
        v[d] = ncq_pkg::comp_t'((CODE_ROM[row][d] + CODE_ROM[other][d]) >>> 1);
      else begin
        case ($urandom_range(0, 3))
          0:       v[d] = 16'sh8000;
          1:       v[d] = 16'sh7FFF;
          2:       v[d] = '0;
          default: v[d] = '1;
        endcase
      end
    end
    send_voxel(v[0], v[1], v[2]);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range extremes
    send_voxel(16'sh8000, 16'sh8000, 16'sh8000);
    send_voxel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_voxel(16'sh0000, 16'sh0000, 16'sh0000);
    send_voxel(-16'sd1,   -16'sd1,   -16'sd1);
    send_voxel(16'sh8000, 16'sh7FFF, 16'sh8000);
    // Every codeword hit exactly
    for (int r = 0; r < 16; r++)
      send_voxel(ncq_pkg::comp_t'(CODE_ROM[r][0]), ncq_pkg::comp_t'(CODE_ROM[r][1]),
                 ncq_pkg::comp_t'(CODE_ROM[r][2]));
    // Exact ties: midpoints of 13/15 and of 7/9, lower index must win
    send_voxel(-16'sd1397, 16'sd537,  16'sd1158);
    send_voxel(16'sd1675,  16'sd1553, -16'sd6004);
    drain_results();

    // Random blocks; one block always runs without idling
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      calm = (blk == 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < BLOCK_VOXELS; i++) send_random_voxel();
      if (blk == RANDOM_BLOCKS / 2) drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> nearest_codeword_quantizer.f
hdl/ncq_pkg.sv
hdl/ncq_cell.sv
hdl/nearest_codeword_quantizer.sv
tb/sv/tb_top.sv
